FILE: src/idq_pkg.sv
`timescale 1ns / 1ps

package idq_pkg;

  localparam int DEF_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int INDEX_W   = 8;
  localparam int FUNC_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd3;
  localparam logic [FUNC_W-1:0] FN_READ_FRONT = 4'd4;
  localparam logic [FUNC_W-1:0] FN_READ_BACK  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_READ_AT    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_INSERT_AT  = 4'd7;
  localparam logic [FUNC_W-1:0] FN_REMOVE_AT  = 4'd8;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    logic [INDEX_W-1:0]       index;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
  } rsp_t;

  // shift command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctl_t;

endpackage

FILE: src/indexed_deque_top.sv
`timescale 1ns / 1ps

// channel | valid     | stall     | payload
// --------+-----------+-----------+--------------------------------------
// request | req_valid | req_stall | req (func, value, index)
// result  | rsp_valid | rsp_stall | rsp (data, status, count, is_empty)
//
// one transaction per cycle unless req_stall; result shows in the cycle after take
// the whole cell row shifts by one place at once, which sets the rate
// rst clears the count and the result valid; entries need no reset
// req_stall is high only while a finished result waits under rsp_stall

module indexed_deque_top #(
  parameter int DEPTH = idq_pkg::DEF_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  idq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output idq_pkg::rsp_t rsp
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = CW + idq_pkg::INDEX_W;
  localparam logic [CW-1:0] FULL_CNT = DEPTH[CW-1:0];

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic signed [idq_pkg::DATA_W-1:0] cell_q [DEPTH];

  idq_pkg::cell_ctl_t ctl;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      rd_pos;
  logic               rd_hit;
  logic [idq_pkg::STATUS_W-1:0] status;
  logic [CMPW-1:0]    idx_ext;
  logic [CMPW-1:0]    cnt_ext;
  logic [PW-1:0]      back_pos;
  logic               full;
  logic               empty;
  logic               take;

  assign req_stall = rsp_valid & rsp_stall;
  assign take      = req_valid & ~req_stall;

  assign idx_ext  = {{CW{1'b0}}, req.index};
  assign cnt_ext  = {{idq_pkg::INDEX_W{1'b0}}, count};
  assign back_pos = count[PW-1:0] - 1'b1;
  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);

  always_comb begin
    ctl        = '0;
    pos        = '0;
    rd_pos     = '0;
    rd_hit     = 1'b0;
    status     = idq_pkg::ST_OK;
    count_next = count;
    case (req.func)
      idq_pkg::FN_PUSH_BACK, idq_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          pos        = (req.func == idq_pkg::FN_PUSH_BACK) ? count[PW-1:0] : '0;
          count_next = count + 1'b1;
        end
      end
      idq_pkg::FN_POP_FRONT, idq_pkg::FN_POP_BACK: begin
        if (empty) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          ctl.del    = 1'b1;
          pos        = (req.func == idq_pkg::FN_POP_FRONT) ? '0 : back_pos;
          rd_pos     = pos;
          rd_hit     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      idq_pkg::FN_READ_FRONT, idq_pkg::FN_READ_BACK: begin
        if (empty) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          rd_pos = (req.func == idq_pkg::FN_READ_FRONT) ? '0 : back_pos;
          rd_hit = 1'b1;
        end
      end
      idq_pkg::FN_READ_AT: begin
        if (idx_ext >= cnt_ext) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          rd_pos = req.index[PW-1:0];
          rd_hit = 1'b1;
        end
      end
      idq_pkg::FN_INSERT_AT: begin
        // range is checked before fullness
        if (idx_ext > cnt_ext) begin
          status = idq_pkg::ST_RANGE;
        end else if (full) begin
          status = idq_pkg::ST_FULL;
        end else begin
          ctl.ins    = 1'b1;
          pos        = req.index[PW-1:0];
          count_next = count + 1'b1;
        end
      end
      idq_pkg::FN_REMOVE_AT: begin
        if (idx_ext >= cnt_ext) begin
          status = idq_pkg::ST_RANGE;
        end else begin
          ctl.del    = 1'b1;
          pos        = req.index[PW-1:0];
          rd_pos     = pos;
          rd_hit     = 1'b1;
          count_next = count - 1'b1;
        end
      end
      idq_pkg::FN_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    if (!take) begin
      ctl = '0;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [idq_pkg::DATA_W-1:0] left;
      logic signed [idq_pkg::DATA_W-1:0] right;
      if (g == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = cell_q[g+1];
      end
      idq_cell #(
        .DEPTH (DEPTH),
        .POS   (g)
      ) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .pos   (pos),
        .value (req.value),
        .left  (left),
        .right (right),
        .q     (cell_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.data     <= rd_hit ? cell_q[rd_pos] : '0;
      rsp.status   <= status;
      rsp.count    <= idq_pkg::COUNT_W'(count_next);
      rsp.is_empty <= (count_next == '0);
    end
  end

endmodule

FILE: src/idq_cell.sv
`timescale 1ns / 1ps

module idq_cell #(
  parameter int DEPTH = idq_pkg::DEF_DEPTH,
  parameter int POS   = 0
) (
  input  logic                             clk,
  input  idq_pkg::cell_ctl_t               ctl,
  input  logic [$clog2(DEPTH)-1:0]         pos,
  input  logic signed [idq_pkg::DATA_W-1:0] value,
  input  logic signed [idq_pkg::DATA_W-1:0] left,
  input  logic signed [idq_pkg::DATA_W-1:0] right,
  output logic signed [idq_pkg::DATA_W-1:0] q
);

  localparam int PW = $clog2(DEPTH);
  localparam logic [PW-1:0] ME = POS[PW-1:0];

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (ME == pos) begin
        q <= value;
      end else if (ME > pos) begin
        q <= left;
      end
    end else if (ctl.del) begin
      // close the gap: everything at or above the removed slot moves down
      if (ME >= pos) begin
        q <= right;
      end
    end
  end

endmodule
